>>> rtl/core/ean8_pkg.sv
// Shared types, constants and symbol lookup for the EAN-8 raster generator.
// No dependencies; the output interface, the generator, the divider, the skid buffer and the testbench use it.
`default_nettype none

package ean8_pkg;

  // Geometry of the symbol in modules
  localparam logic [6:0] NUM_MODULES  = 7'd67;
  localparam logic [6:0] CENTRE_START = 7'd31;
  localparam logic [6:0] RIGHT_START  = 7'd36;
  localparam logic [6:0] END_START    = 7'd64;
  localparam logic [6:0] DIGITS_START = 7'd3;

  // Counter widths
  localparam int COL_W = 12;
  localparam int ROW_W = 11;
  localparam int IDX_W = 7;
  localparam int DIM_W = 11;

  // Default saturation limit for the module width
  localparam int MODULE_WIDTH_MAX_DEF = 16;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_DIGITS       = 2'd0;
  localparam logic [1:0] REG_QUIET_ZONE   = 2'd1;
  localparam logic [1:0] REG_MODULE_WIDTH = 2'd2;
  localparam logic [1:0] REG_BAR_HEIGHT   = 2'd3;

  // L codes, first module in bit 6; codes above nine give an all-white digit
  localparam logic [6:0] L_TABLE [16] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B,
    7'h37, 7'h0B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic             pixel;
    logic             row_end;
    logic             image_end;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } out_pay_t;

  // One module of a digit: pick the code, invert on the right half
  function automatic logic digit_bit(logic [31:0] digits, logic [2:0] digit_no,
                                     logic [2:0] pos, logic right);
    logic [3:0] d;
    logic [6:0] code;
    d = digits[{digit_no, 2'b00} +: 4];
    code = L_TABLE[d];
    if (right) begin
      code = ~code;
    end
    return (d <= 4'd9) && code[3'd6 - pos];
  endfunction

  // Split an offset into a digit half (0..27) into digit and position
  function automatic logic [4:0] digit_split(logic [4:0] t);
    logic [1:0] dg;
    logic [4:0] ps;
    if (t >= 5'd21) begin
      dg = 2'd3;
    end else if (t >= 5'd14) begin
      dg = 2'd2;
    end else if (t >= 5'd7) begin
      dg = 2'd1;
    end else begin
      dg = 2'd0;
    end
    ps = t - 5'(dg) * 5'd7;
    return {dg, ps[2:0]};
  endfunction

  // Bar or space of one module of the symbol
  function automatic logic module_bit(idx_t m, logic [31:0] digits);
    logic [4:0] sp;
    logic       b;
    b = 1'b0;
    sp = '0;
    if (m < DIGITS_START) begin
      b = (m != 7'd1);
    end else if (m < CENTRE_START) begin
      sp = digit_split(5'(m - DIGITS_START));
      b = digit_bit(digits, {1'b0, sp[4:3]}, sp[2:0], 1'b0);
    end else if (m < RIGHT_START) begin
      b = ~m[0];
    end else if (m < END_START) begin
      sp = digit_split(5'(m - RIGHT_START));
      b = digit_bit(digits, {1'b1, sp[4:3]}, sp[2:0], 1'b1);
    end else if (m < NUM_MODULES) begin
      b = (m != END_START + 7'd1);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ean8_in_if.sv
// Input channel of the EAN-8 raster generator: one beat requests one pixel.
// Depends on nothing.
`default_nettype none

interface ean8_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ean8_out_if.sv
// Result channel of the EAN-8 raster generator: one beat carries one pixel.
// Depends on ean8_pkg for field widths.
`default_nettype none

interface ean8_out_if;
  logic                     valid;
  logic                     ready;
  logic                     pixel;
  logic                     row_end;
  logic                     image_end;
  logic [ean8_pkg::DIM_W-1:0] image_width;
  logic [ean8_pkg::DIM_W-1:0] image_height;

  modport source(output valid, output pixel, output row_end, output image_end,
                 output image_width, output image_height, input ready);
  modport sink(input valid, input pixel, input row_end, input image_end,
               input image_width, input image_height, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ean8_cfg_if.sv
// Configuration write channel of the EAN-8 raster generator.
// Depends on nothing.
`default_nettype none

interface ean8_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ean8_barcode_raster.sv
// EAN-8 barcode raster generator: each input beat yields one pixel of the image in raster
// order, with row and image end flags and the image size. One pixel per clock cycle is
// sustained while the output buffer has room and no divide runs; the pixel is looked up
// from the position counters and registered in a two-entry output buffer. The module
// index within the bars is tracked incrementally, so after reset and every configuration
// write a restoring divider re-derives it from the column at one quotient bit per cycle.
`default_nettype none

module ean8_barcode_raster #(
  parameter int MAX_MODULE_WIDTH = ean8_pkg::MODULE_WIDTH_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ean8_in_if.sink          in_if,
  ean8_out_if.source       out_if,
  ean8_cfg_if.sink         cfg_if
);
  import ean8_pkg::*;

  localparam int SUB_W = (MAX_MODULE_WIDTH > 1) ? $clog2(MAX_MODULE_WIDTH) : 1;
  localparam logic [4:0] MW_SAT = (MAX_MODULE_WIDTH > 31) ? 5'd31 : 5'(MAX_MODULE_WIDTH);

  // Configuration registers
  logic [31:0] digits_r;
  logic [7:0]  qz_r;
  logic [4:0]  mw_r;
  logic [9:0]  bh_r;

  // Derived geometry
  logic [4:0]  mw_eff;
  logic [9:0]  bh_eff;
  col_t        width_r;
  col_t        width_m1_r;
  col_t        bar_col_end_r;
  row_t        height_r;
  row_t        height_m1_r;
  row_t        bar_row_end_r;

  // Position state
  row_t             row_r;
  col_t             col_r;
  idx_t             idx_r;
  logic [SUB_W-1:0] sub_r;
  logic             start_r;

  // Current beat
  logic             in_fire;
  logic             cfg_fire;
  logic             skid_ready;
  row_t             row_c;
  col_t             col_c;
  idx_t             idx_c;
  logic [SUB_W-1:0] sub_c;
  logic             in_cols;
  logic             in_rows;
  logic             row_end;
  logic             image_end;
  logic             sub_wrap;
  out_pay_t         pay;
  out_pay_t         out_pay;

  // Divider results
  logic             div_busy;
  logic             div_done;
  idx_t             div_idx;
  logic [SUB_W-1:0] div_sub;

  // Hold off input beats until the divider result is loaded
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid & cfg_if.ready;
  assign in_if.ready  = skid_ready & ~start_r & ~div_busy & ~div_done;
  assign in_fire      = in_if.valid & in_if.ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
      qz_r     <= '0;
      mw_r     <= 5'd1;
      bh_r     <= 10'd1;
    end else if (cfg_fire) begin
      unique case (cfg_if.index)
        REG_DIGITS:       digits_r <= cfg_if.data;
        REG_QUIET_ZONE:   qz_r     <= cfg_if.data[7:0];
        REG_MODULE_WIDTH: mw_r     <= cfg_if.data[4:0];
        REG_BAR_HEIGHT:   bh_r     <= cfg_if.data[9:0];
        default: ;
      endcase
    end
  end

  // Clamp module width and bar height
  assign mw_eff = (mw_r == 5'd0) ? 5'd1 : ((mw_r > MW_SAT) ? MW_SAT : mw_r);
  assign bh_eff = (bh_r == 10'd0) ? 10'd1 : bh_r;

  // Register the geometry; it settles while the divider runs
  always_ff @(posedge clk) begin
    width_r       <= COL_W'(NUM_MODULES) * COL_W'(mw_eff) + COL_W'({qz_r, 1'b0});
    width_m1_r    <= width_r - COL_W'(1);
    bar_col_end_r <= COL_W'(qz_r) + COL_W'(NUM_MODULES) * COL_W'(mw_eff);
    height_r      <= ROW_W'(bh_eff) + ROW_W'({qz_r, 1'b0});
    height_m1_r   <= height_r - ROW_W'(1);
    bar_row_end_r <= ROW_W'(qz_r) + ROW_W'(bh_eff);
  end

  // Position of this beat; restart jumps to the top-left pixel
  assign row_c = in_if.restart ? '0 : row_r;
  assign col_c = in_if.restart ? '0 : col_r;
  assign idx_c = in_if.restart ? '0 : idx_r;
  assign sub_c = in_if.restart ? '0 : sub_r;

  assign in_cols   = (col_c >= COL_W'(qz_r)) && (col_c < bar_col_end_r);
  assign in_rows   = (row_c >= ROW_W'(qz_r)) && (row_c < bar_row_end_r);
  assign row_end   = col_c >= width_m1_r;
  assign image_end = row_end && (row_c >= height_m1_r);
  assign sub_wrap  = (6'(sub_c) + 6'd1) == 6'(mw_eff);

  always_comb begin
    pay.pixel        = in_cols & in_rows & module_bit(idx_c, digits_r);
    pay.row_end      = row_end;
    pay.image_end    = image_end;
    pay.image_width  = width_r[DIM_W-1:0];
    pay.image_height = height_r;
  end

  // Advance the position; reload module index after a divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      idx_r   <= '0;
      sub_r   <= '0;
      start_r <= 1'b1;
    end else begin
      start_r <= cfg_fire;
      if (div_done) begin
        idx_r <= div_idx;
        sub_r <= div_sub;
      end else if (in_fire) begin
        if (image_end) begin
          row_r <= '0;
          col_r <= '0;
          idx_r <= '0;
          sub_r <= '0;
        end else if (row_end) begin
          row_r <= row_c + ROW_W'(1);
          col_r <= '0;
          idx_r <= '0;
          sub_r <= '0;
        end else begin
          row_r <= row_c;
          col_r <= col_c + COL_W'(1);
          if (in_cols && sub_wrap) begin
            idx_r <= idx_c + IDX_W'(1);
            sub_r <= '0;
          end else if (in_cols) begin
            idx_r <= idx_c;
            sub_r <= sub_c + SUB_W'(1);
          end else begin
            idx_r <= idx_c;
            sub_r <= sub_c;
          end
        end
      end
    end
  end

  ean8_col_div #(
    .SUB_W(SUB_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .col   (col_r),
    .qz    (qz_r),
    .mw    (mw_eff),
    .busy  (div_busy),
    .done  (div_done),
    .idx   (div_idx),
    .sub   (div_sub)
  );

  ean8_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_fire),
    .in_ready  (skid_ready),
    .in_pay    (pay),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_pay   (out_pay)
  );

  assign out_if.pixel        = out_pay.pixel;
  assign out_if.row_end      = out_pay.row_end;
  assign out_if.image_end    = out_pay.image_end;
  assign out_if.image_width  = out_pay.image_width;
  assign out_if.image_height = out_pay.image_height;

  // A register write holds off input beats until the module index is re-derived
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !in_if.ready)
    else $error("input beat possible right after a register write");

  // Left of the bars the module counters must be zero once settled
  assert property (@(posedge clk) disable iff (!rst_n)
    (!start_r && !div_busy && !div_done && (col_r < COL_W'(qz_r))) |->
      (idx_r == '0 && sub_r == '0))
    else $error("module counters not cleared in the quiet zone");

  // An image end is always a row end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (!out_if.image_end || out_if.row_end))
    else $error("image end without row end");

  // The divider finishes before an item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !$past(in_fire))
    else $error("input beat taken during a divide");

endmodule

`default_nettype wire

>>> rtl/core/ean8_col_div.sv
// Restoring divider that re-derives module index and subpixel from the column.
// Depends on ean8_pkg.
`default_nettype none

module ean8_col_div #(
  parameter int SUB_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ean8_pkg::col_t       col,
  input  logic [7:0]           qz,
  input  logic [4:0]           mw,
  output logic                 busy,
  output logic                 done,
  output ean8_pkg::idx_t       idx,
  output logic [SUB_W-1:0]     sub
);
  import ean8_pkg::*;

  localparam int CNT_W = $clog2(COL_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [4:0]       rem_r;
  logic [4:0]       rem_nxt;
  col_t             quo_r;
  col_t             quo_nxt;
  col_t             off;
  logic [5:0]       trial;
  logic [5:0]       diff;
  logic             ge;

  // Offset into the bar region; a column left of it divides zero
  assign off = (col >= COL_W'(qz)) ? col - COL_W'(qz) : '0;

  // One quotient bit per cycle
  assign trial   = {rem_r, quo_r[COL_W-1]};
  assign ge      = trial >= {1'b0, mw};
  assign diff    = trial - {1'b0, mw};
  assign rem_nxt = ge ? diff[4:0] : trial[4:0];
  assign quo_nxt = {quo_r[COL_W-2:0], ge};

  // Control: start loads, count down the steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(COL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= off;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign idx  = quo_r[IDX_W-1:0];
  assign sub  = SUB_W'(rem_r);

endmodule

`default_nettype wire

>>> rtl/core/ean8_out_skid.sv
// Two-entry result buffer (output register plus skid register).
// Depends on ean8_pkg for the result payload type.
`default_nettype none

module ean8_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ean8_pkg::out_pay_t in_pay,
  output logic               out_valid,
  input  logic               out_ready,
  output ean8_pkg::out_pay_t out_pay
);
  import ean8_pkg::*;

  logic     main_v_r;
  logic     skid_v_r;
  out_pay_t main_r;
  out_pay_t skid_r;
  logic     pop;
  logic     push;

  assign in_ready  = ~skid_v_r;
  assign push      = in_valid & ~skid_v_r;
  assign pop       = main_v_r & out_ready;
  assign out_valid = main_v_r;
  assign out_pay   = main_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end
  end

  // Payload: refill the output register from the skid stage first
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= in_pay;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_r <= in_pay;
      end else begin
        main_r <= in_pay;
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_ean8_barcode_raster.sv
// Testbench for the EAN-8 barcode raster generator: self-checking, pixel by pixel.
// Depends on ean8_pkg, the three channel interfaces and ean8_barcode_raster.
`timescale 1ns / 1ps

module tb_ean8_barcode_raster;
  import ean8_pkg::*;

  localparam int MAX_MW      = 16;
  localparam int SYMBOL_MODS = 67;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 20;
  localparam int RANDOM_ITEMS = 700;

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;

  ean8_in_if  in_if();
  ean8_out_if out_if();
  ean8_cfg_if cfg_if();

  ean8_barcode_raster #(.MAX_MODULE_WIDTH(MAX_MW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Raster predictor and queue of pixels still owed by the block
  class raster_scoreboard;
    logic [31:0] digits;
    logic [7:0]  quiet;
    logic [4:0]  mod_w_reg;
    logic [9:0]  bar_h_reg;
    int unsigned row_pos;
    int unsigned col_pos;
    out_pay_t    owed_pixels[$];
    int unsigned fail_count;

    function new();
      digits     = '0;
      quiet      = '0;
      mod_w_reg  = 5'd1;
      bar_h_reg  = 10'd1;
      row_pos    = 0;
      col_pos    = 0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_DIGITS:       digits    = value;
        REG_QUIET_ZONE:   quiet     = value[7:0];
        REG_MODULE_WIDTH: mod_w_reg = value[4:0];
        REG_BAR_HEIGHT:   bar_h_reg = value[9:0];
        default: ;
      endcase
    endfunction

    // Left-half pattern of one digit, first module in bit 6
    function logic [6:0] left_code(logic [3:0] d);
      case (d)
        4'd0: return 7'b0001101;
        4'd1: return 7'b0011001;
        4'd2: return 7'b0010011;
        4'd3: return 7'b0111101;
        4'd4: return 7'b0100011;
        4'd5: return 7'b0110001;
        4'd6: return 7'b0101111;
        4'd7: return 7'b0111011;
        4'd8: return 7'b0110111;
        4'd9: return 7'b0001011;
        default: return 7'b0000000;
      endcase
    endfunction

    function bit digit_module(int unsigned dn, int unsigned pos, bit right_half);
      logic [3:0] d;
      logic [6:0] code;
      d = digits[dn*4 +: 4];
      if (d > 4'd9) return 1'b0;
      code = left_code(d);
      if (right_half) code = ~code;
      return code[6 - pos];
    endfunction

    // Bar or space for module m of the symbol
    function bit symbol_bit(int unsigned m);
      if (m < 3) return m != 1;
      if (m < 31) return digit_module((m - 3) / 7, (m - 3) % 7, 1'b0);
      if (m < 36) return (m - 31) & 1;
      if (m < 64) return digit_module(4 + (m - 36) / 7, (m - 36) % 7, 1'b1);
      if (m < SYMBOL_MODS) return (m - 64) != 1;
      return 1'b0;
    endfunction

    function void note_request(logic restart);
      int unsigned mw, bh, width, height;
      out_pay_t    px;
      mw = (mod_w_reg == 0) ? 1 : ((mod_w_reg > MAX_MW) ? MAX_MW : mod_w_reg);
      bh = (bar_h_reg == 0) ? 1 : bar_h_reg;
      width  = SYMBOL_MODS * mw + 2 * quiet;
      height = bh + 2 * quiet;
      if (restart) begin
        row_pos = 0;
        col_pos = 0;
      end
      px.pixel = 1'b0;
      if (col_pos >= quiet && col_pos < quiet + SYMBOL_MODS * mw &&
          row_pos >= quiet && row_pos < quiet + bh) begin
        px.pixel = symbol_bit((col_pos - quiet) / mw);
      end
      px.row_end      = col_pos >= width - 1;
      px.image_end    = px.row_end && row_pos >= height - 1;
      px.image_width  = width[DIM_W-1:0];
      px.image_height = height[DIM_W-1:0];
      owed_pixels.push_back(px);
      // Advance the raster position, wrapping at the end of the image
      if (px.image_end) begin
        row_pos = 0;
        col_pos = 0;
      end else if (px.row_end) begin
        row_pos++;
        col_pos = 0;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_pixel(out_pay_t got);
      out_pay_t exp_px;
      if (owed_pixels.size() == 0) begin
        $error("pixel beat with nothing expected");
        fail_count++;
        return;
      end
      exp_px = owed_pixels.pop_front();
      if (got.pixel !== exp_px.pixel) begin
        $error("pixel: expected %0d, got %0d", exp_px.pixel, got.pixel);
        fail_count++;
      end
      if (got.row_end !== exp_px.row_end) begin
        $error("row_end: expected %0d, got %0d", exp_px.row_end, got.row_end);
        fail_count++;
      end
      if (got.image_end !== exp_px.image_end) begin
        $error("image_end: expected %0d, got %0d", exp_px.image_end, got.image_end);
        fail_count++;
      end
      if (got.image_width !== exp_px.image_width) begin
        $error("image_width: expected %0d, got %0d", exp_px.image_width, got.image_width);
        fail_count++;
      end
      if (got.image_height !== exp_px.image_height) begin
        $error("image_height: expected %0d, got %0d", exp_px.image_height,
               got.image_height);
        fail_count++;
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  raster_scoreboard sb = new();
  int unsigned stall_cycles = 0;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample all three channels, check results and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_pixel({out_if.pixel, out_if.row_end, out_if.image_end,
                        out_if.image_width, out_if.image_height});
      end
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_request(in_if.restart);
      if ((out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (in_if.valid && in_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_ean8_barcode_raster NOT OK");
        $finish;
      end
    end
  end

  // Receiver: hold ready for a while, then stall unless in a calm stretch
  initial begin : sink_ready
    int hold, gap;
    out_if.ready = 1'b0;
    forever begin
      hold = $urandom_range(1, 24);
      gap  = calm ? 0 : idle_len();
      repeat (hold) begin
        @(negedge clk);
        out_if.ready = 1'b1;
      end
      repeat (gap) begin
        @(negedge clk);
        out_if.ready = 1'b0;
      end
    end
  end

  // Request one pixel, after an optional gap
  task automatic send_pixel(input logic rs);
    int gap;
    gap = calm ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.restart = rs;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic stop_requests();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic setup_all(input logic [31:0] dg, input logic [31:0] qz,
                           input logic [31:0] mw, input logic [31:0] bh);
    write_reg(REG_DIGITS, dg);
    write_reg(REG_QUIET_ZONE, qz);
    write_reg(REG_MODULE_WIDTH, mw);
    write_reg(REG_BAR_HEIGHT, bh);
  endtask

  // Pick a new geometry: mostly tiny images, sometimes the largest ones
  task automatic random_setup(input bit big);
    logic [31:0] dg, qz, mw, bh;
    int r;
    dg = $urandom();
    if ($urandom_range(0, 1) == 0) begin
      for (int k = 0; k < 8; k++) dg[k*4 +: 4] = $urandom_range(0, 9);
    end
    qz = $urandom();
    mw = $urandom();
    bh = $urandom();
    if (big) begin
      qz[7:0] = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(150, 255));
      mw[4:0] = 5'($urandom_range(MAX_MW, 31));
      bh[9:0] = ($urandom_range(0, 1) == 0) ? 10'd1023 : 10'($urandom_range(600, 1023));
    end else begin
      r = $urandom_range(0, 99);
      qz[7:0] = (r < 50) ? 8'd0 : (r < 90) ? 8'($urandom_range(1, 3)) :
                8'($urandom_range(4, 10));
      r = $urandom_range(0, 99);
      mw[4:0] = (r < 60) ? 5'd1 : (r < 80) ? 5'd0 : (r < 95) ? 5'($urandom_range(2, 4)) :
                5'($urandom_range(MAX_MW + 1, 31));
      r = $urandom_range(0, 99);
      bh[9:0] = (r < 40) ? 10'd1 : (r < 60) ? 10'd0 : 10'($urandom_range(2, 6));
    end
    setup_all(dg, qz, mw, bh);
  endtask

  initial begin : stimulus
    int  n, random_items;
    bit  big;
    random_items  = 0;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_DIGITS;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Defaults after reset: start guard
    calm = 1'b1;
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b0);
    stop_requests();
    wait_drained();

    // Every register at its top value, saturated module width, widest image
    setup_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b0);
    stop_requests();
    wait_drained();

    // Zero width and height fall back to one; restart mid-row
    setup_all(32'h7654_3210, 32'h0, 32'h0, 32'h0);
    send_pixel(1'b1);
    repeat (14) send_pixel(1'b0);
    calm = 1'b0;

    // Random phases, each with a fresh geometry
    while (random_items < RANDOM_ITEMS) begin
      stop_requests();
      wait_drained();
      big = ($urandom_range(0, 9) == 0);
      random_setup(big);
      calm = ($urandom_range(0, 3) == 0);
      n = big ? $urandom_range(20, 40) : $urandom_range(40, 100);
      for (int i = 0; i < n; i++) begin
        if (!calm && $urandom_range(0, 29) == 0) begin
          stop_requests();
          wait_drained();
        end
        send_pixel($urandom_range(0, 49) == 0);
        random_items++;
      end
    end

    // Drain and let the block settle
    stop_requests();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d pixel beats never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("tb_ean8_barcode_raster OK");
    end else begin
      $display("tb_ean8_barcode_raster NOT OK");
    end
    $finish;
  end

endmodule

>>> ean8_barcode_raster.f
rtl/core/ean8_pkg.sv
rtl/core/ean8_in_if.sv
rtl/core/ean8_out_if.sv
rtl/core/ean8_cfg_if.sv
rtl/core/ean8_col_div.sv
rtl/core/ean8_out_skid.sv
rtl/core/ean8_barcode_raster.sv
verif/tb_ean8_barcode_raster.sv
